// File: rtl/core/bpl_pkg.sv
// Shared types and constants for the bounded positional list core.
package bpl_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int CNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
    logic [CNT_W-1:0] count;
    logic             is_full;
    logic             is_empty;
  } result_t;

endpackage

// File: rtl/core/bpl_ifs.sv
// Channel interfaces for request, response and capacity beats.
interface bpl_req_if;
  logic                       valid;
  logic                       ready;
  logic [bpl_pkg::FUNC_W-1:0] func;
  logic [bpl_pkg::POS_W-1:0]  position;
  logic [bpl_pkg::VAL_W-1:0]  value;

  modport source(output valid, func, position, value, input ready);
  modport sink(input valid, func, position, value, output ready);
endinterface

interface bpl_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bpl_pkg::VAL_W-1:0] read_value;
  logic                      status;
  logic [bpl_pkg::CNT_W-1:0] count;
  logic                      is_full;
  logic                      is_empty;

  modport source(output valid, read_value, status, count, is_full, is_empty, input ready);
  modport sink(input valid, read_value, status, count, is_full, is_empty, output ready);
endinterface

interface bpl_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpl_pkg::CAP_W-1:0] capacity;

  modport source(output valid, capacity, input ready);
  modport sink(input valid, capacity, output ready);
endinterface

// File: rtl/core/bounded_positional_list_core.sv
// Sequence: append, insert at the end, refused op or delete of the last entry go straight to the
// done state; read passes a read-wait state; insert at p < n shifts the entries from p up, then writes
// at p; delete at p shifts the later entries down. Results leave via the response register.
// Flow: one request at a time; each shifted entry costs a read and a write pass through the entry
// RAM; idle again once the result enters the response register.
// Reset: count clears to zero and capacity to 16; entry storage is not cleared.
module bounded_positional_list_core #(
  parameter int DEPTH      = bpl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bpl_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bpl_req_if.sink   req,
  bpl_rsp_if.source rsp,
  bpl_cfg_if.sink   cfg
);

  logic [bpl_pkg::CAP_W-1:0] capacity;
  logic                      res_valid;
  logic                      res_ready;
  bpl_pkg::result_t          res;
  logic                      rsp_valid;
  bpl_pkg::result_t          rsp_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bpl_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.capacity;
    end
  end

  bpl_seq #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .func     (bpl_pkg::func_t'(req.func)),
    .position (req.position),
    .value    (req.value),
    .capacity (capacity),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_data.read_value;
  assign rsp.status     = rsp_data.status;
  assign rsp.count      = rsp_data.count;
  assign rsp.is_full    = rsp_data.is_full;
  assign rsp.is_empty   = rsp_data.is_empty;

endmodule

// File: rtl/core/bpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpl_ram #(
  parameter int WIDTH = bpl_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = bpl_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bpl_idx_unit.sv
// Shared index step unit: one increment or decrement and a limit compare.
module bpl_idx_unit #(
  parameter int W = 5
) (
  input  logic [W-1:0] idx,
  input  logic         up,
  input  logic [W-1:0] limit,
  output logic [W-1:0] step,
  output logic         hit
);

  assign step = up ? (idx + W'(1)) : (idx - W'(1));
  assign hit  = (step == limit);

endmodule

// File: rtl/core/bpl_seq.sv
// Operation sequencer: list count, entry memory and one-step-per-pass shifting.
module bpl_seq #(
  parameter int DEPTH      = bpl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bpl_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bpl_pkg::func_t            func,
  input  logic [bpl_pkg::POS_W-1:0] position,
  input  logic [bpl_pkg::VAL_W-1:0] value,
  input  logic [bpl_pkg::CAP_W-1:0] capacity,
  output logic                      res_valid,
  input  logic                      res_ready,
  output bpl_pkg::result_t          res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > bpl_pkg::POS_W) ? CW : bpl_pkg::POS_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SHIFT_RD  = 6'b000010,
    ST_SHIFT_WR  = 6'b000100,
    ST_PUT       = 6'b001000,
    ST_READ_WAIT = 6'b010000,
    ST_DONE      = 6'b100000
  } state_t;

  state_t                    state, state_next;
  logic [W-1:0]              used, used_next;
  logic [W-1:0]              idx, idx_next;
  logic [W-1:0]              limit, limit_next;
  bpl_pkg::func_t            op, op_next;
  logic [DATA_WIDTH-1:0]     val_r, val_next;
  logic [bpl_pkg::VAL_W-1:0] rd_r, rd_next;
  logic                      status_r, status_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic [W-1:0] step;
  logic         hit;

  logic [W-1:0] cap_w, depth_w, cap_eff, pos_w;
  logic [W-1:0] start, lim;
  logic         full, ok;

  bpl_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bpl_idx_unit #(
    .W(W)
  ) u_idx (
    .idx  (idx),
    .up   (op == bpl_pkg::FN_DELETE),
    .limit(limit),
    .step (step),
    .hit  (hit)
  );

  assign cap_w   = W'(capacity);
  assign depth_w = W'(DEPTH);
  assign cap_eff = (cap_w > depth_w) ? depth_w : cap_w;
  assign pos_w   = W'(position);
  assign full    = (used >= cap_eff);

  always_comb begin
    unique case (func)
      bpl_pkg::FN_APPEND: begin
        ok    = !full;
        start = used;
        lim   = used;
      end
      bpl_pkg::FN_INSERT: begin
        ok    = !full && (pos_w <= used);
        start = used;
        lim   = pos_w;
      end
      bpl_pkg::FN_DELETE: begin
        ok    = (pos_w < used);
        start = pos_w;
        lim   = used - W'(1);
      end
      default: begin
        ok    = (pos_w < used);
        start = pos_w;
        lim   = pos_w;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    used_next   = used;
    idx_next    = idx;
    limit_next  = limit;
    op_next     = op;
    val_next    = val_r;
    rd_next     = rd_r;
    status_next = status_r;
    we          = 1'b0;
    waddr       = limit[AW-1:0];
    wdata       = val_r;
    raddr       = step[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next     = func;
          val_next    = DATA_WIDTH'(value);
          rd_next     = '0;
          status_next = !ok;
          idx_next    = start;
          limit_next  = lim;
          if (!ok) begin
            state_next = ST_DONE;
          end else begin
            unique case (func)
              bpl_pkg::FN_APPEND, bpl_pkg::FN_INSERT: begin
                if (start == lim) begin
                  we         = 1'b1;
                  waddr      = lim[AW-1:0];
                  wdata      = DATA_WIDTH'(value);
                  used_next  = used + W'(1);
                  state_next = ST_DONE;
                end else begin
                  state_next = ST_SHIFT_RD;
                end
              end
              bpl_pkg::FN_DELETE: begin
                if (start == lim) begin
                  used_next  = used - W'(1);
                  state_next = ST_DONE;
                end else begin
                  state_next = ST_SHIFT_RD;
                end
              end
              default: begin
                raddr      = pos_w[AW-1:0];
                state_next = ST_READ_WAIT;
              end
            endcase
          end
        end
      end
      ST_SHIFT_RD: begin
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        we       = 1'b1;
        waddr    = idx[AW-1:0];
        wdata    = rdata;
        idx_next = step;
        if (hit) begin
          if (op == bpl_pkg::FN_DELETE) begin
            used_next  = used - W'(1);
            state_next = ST_DONE;
          end else begin
            state_next = ST_PUT;
          end
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_PUT: begin
        we         = 1'b1;
        used_next  = used + W'(1);
        state_next = ST_DONE;
      end
      ST_READ_WAIT: begin
        rd_next    = bpl_pkg::VAL_W'(rdata);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    limit    <= limit_next;
    op       <= op_next;
    val_r    <= val_next;
    rd_r     <= rd_next;
    status_r <= status_next;
  end

  assign res_valid      = (state == ST_DONE);
  assign res.read_value = rd_r;
  assign res.status     = status_r;
  assign res.count      = used[bpl_pkg::CNT_W-1:0];
  assign res.is_full    = full;
  assign res.is_empty   = (used == '0);

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= depth_w)
    else $error("list count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_done_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> $stable(used))
    else $error("count moved while result pending");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_RD || state == ST_SHIFT_WR) |-> (idx < depth_w && step < depth_w))
    else $error("shift index out of range");

endmodule

// File: tb/bpl_list_checker.sv
`timescale 1ns / 100ps
// Watches the list core channels, predicts each response and compares it beat by beat.
module bpl_list_checker (
  input  logic      clk,
  input  logic      rst,
  bpl_req_if        req,
  bpl_rsp_if        rsp,
  bpl_cfg_if        cfg,
  output int        errors,
  output int        pending,
  output int        checked,
  output int        refused
);

  localparam int CELLS = bpl_pkg::DEPTH_DEF;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [bpl_pkg::VAL_W-1:0] cells [CELLS];
  int                        used_q;
  logic [bpl_pkg::CAP_W-1:0] cap_q;
  bpl_pkg::result_t          expected_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    refused = 0;
    used_q  = 0;
    cap_q   = bpl_pkg::CAP_RESET;
    foreach (cells[i]) cells[i] = '0;
  end

  task automatic list_op(input bpl_pkg::func_t f, input logic [bpl_pkg::POS_W-1:0] p,
                         input logic [bpl_pkg::VAL_W-1:0] v, output bpl_pkg::result_t r);
    int                        lim;
    int                        i;
    bit                        full;
    logic [bpl_pkg::VAL_W-1:0] rd;
    logic                      no;
    lim  = (cap_q > CELLS) ? CELLS : int'(cap_q);
    full = used_q >= lim;
    rd   = '0;
    no   = 1'b1;
    unique case (f)
      bpl_pkg::FN_APPEND: begin
        if (!full && used_q < CELLS) begin
          cells[IW'(used_q)] = v;
          used_q++;
          no = 1'b0;
        end
      end
      bpl_pkg::FN_INSERT: begin
        if (!full && used_q < CELLS && int'(p) <= used_q) begin
          for (i = used_q; i > int'(p); i--) cells[IW'(i)] = cells[IW'(i-1)];
          cells[IW'(p)] = v;
          used_q++;
          no = 1'b0;
        end
      end
      bpl_pkg::FN_DELETE: begin
        if (int'(p) < used_q) begin
          for (i = int'(p); i + 1 < used_q; i++) cells[IW'(i)] = cells[IW'(i+1)];
          used_q--;
          no = 1'b0;
        end
      end
      default: begin
        if (int'(p) < used_q) begin
          rd = cells[IW'(p)];
          no = 1'b0;
        end
      end
    endcase
    r.read_value = rd;
    r.status     = no;
    r.count      = used_q[bpl_pkg::CNT_W-1:0];
    r.is_full    = used_q >= lim;
    r.is_empty   = used_q == 0;
  endtask

  task automatic check_field(input string name, input logic [bpl_pkg::VAL_W-1:0] want,
                             input logic [bpl_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bpl_pkg::result_t want;
    if (rst) begin
      used_q = 0;
      cap_q  = bpl_pkg::CAP_RESET;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) cap_q = cfg.capacity;
      if (req.valid && req.ready) begin
        list_op(bpl_pkg::func_t'(req.func), req.position, req.value, want);
        expected_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $error("response beat with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.status) refused++;
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("status", bpl_pkg::VAL_W'(want.status), bpl_pkg::VAL_W'(rsp.status));
          check_field("count", bpl_pkg::VAL_W'(want.count), bpl_pkg::VAL_W'(rsp.count));
          check_field("is_full", bpl_pkg::VAL_W'(want.is_full),
                      bpl_pkg::VAL_W'(rsp.is_full));
          check_field("is_empty", bpl_pkg::VAL_W'(want.is_empty),
                      bpl_pkg::VAL_W'(rsp.is_empty));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the list core testbench: clock, reset, stimulus, idling and the verdict.
module tb;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_ITEMS = 135;
  localparam int CALM_ITEMS  = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  bpl_req_if req_ch ();
  bpl_rsp_if rsp_ch ();
  bpl_cfg_if cfg_ch ();

  bounded_positional_list_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  int errors;
  int pending;
  int checked;
  int refused;

  bpl_list_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked),
    .refused (refused)
  );

  bit calm = 1'b0;
  int cycles = 0;
  int n_ops = 0;
  int n_cfg = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // response side: random stall bursts, none once calm
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || calm) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 10);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // leaves valid high on return; the caller moves on in the same step
  task automatic issue_op(input bpl_pkg::func_t f, input logic [bpl_pkg::POS_W-1:0] p,
                          input logic [bpl_pkg::VAL_W-1:0] v);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= f;
    req_ch.position <= p;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_ops++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [bpl_pkg::CAP_W-1:0] c);
    settle();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_op(input bit filling);
    int                        pick;
    bpl_pkg::func_t            f;
    logic [bpl_pkg::POS_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (filling) begin
      f = (pick < 35) ? bpl_pkg::FN_APPEND :
          (pick < 65) ? bpl_pkg::FN_INSERT :
          (pick < 80) ? bpl_pkg::FN_DELETE : bpl_pkg::FN_READ;
    end else begin
      f = (pick < 10) ? bpl_pkg::FN_APPEND :
          (pick < 25) ? bpl_pkg::FN_INSERT :
          (pick < 75) ? bpl_pkg::FN_DELETE : bpl_pkg::FN_READ;
    end
    if ($urandom_range(0, 99) < 85) begin
      p = bpl_pkg::POS_W'($urandom_range(0, 16));
    end else begin
      p = bpl_pkg::POS_W'($urandom);
    end
    issue_op(f, p, $urandom);
  endtask

  initial begin
    logic [bpl_pkg::CAP_W-1:0] caps [10];
    int                        k;
    int                        n;
    caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd12, 5'd17, 5'd2, 5'd16, 5'd8};
    req_ch.valid    <= 1'b0;
    req_ch.func     <= bpl_pkg::FN_APPEND;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.capacity <= bpl_pkg::CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, default capacity
    issue_op(bpl_pkg::FN_READ, 5'd0, 32'h0);
    issue_op(bpl_pkg::FN_DELETE, 5'd0, 32'h0);
    issue_op(bpl_pkg::FN_INSERT, 5'd1, 32'h1234_5678);
    issue_op(bpl_pkg::FN_INSERT, 5'd0, 32'hFFFF_FFFF);
    issue_op(bpl_pkg::FN_APPEND, 5'd0, 32'h0000_0000);
    issue_op(bpl_pkg::FN_INSERT, 5'd2, 32'hA5A5_A5A5);
    issue_op(bpl_pkg::FN_INSERT, 5'd31, 32'hDEAD_BEEF);
    issue_op(bpl_pkg::FN_READ, 5'd1, 32'h0);
    issue_op(bpl_pkg::FN_READ, 5'd31, 32'h0);
    issue_op(bpl_pkg::FN_DELETE, 5'd2, 32'h0);
    issue_op(bpl_pkg::FN_INSERT, 5'd1, 32'h5A5A_5A5A);
    issue_op(bpl_pkg::FN_DELETE, 5'd0, 32'h0);
    // small capacity reaches full
    set_capacity(5'd3);
    issue_op(bpl_pkg::FN_APPEND, 5'd0, 32'h8000_0001);
    issue_op(bpl_pkg::FN_APPEND, 5'd0, 32'h0F0F_0F0F);
    issue_op(bpl_pkg::FN_INSERT, 5'd0, 32'hF0F0_F0F0);
    issue_op(bpl_pkg::FN_READ, 5'd2, 32'h0);
    // capacity lowered below count
    set_capacity(5'd1);
    issue_op(bpl_pkg::FN_DELETE, 5'd1, 32'h0);
    issue_op(bpl_pkg::FN_APPEND, 5'd0, 32'h1111_1111);
    // capacity zero
    set_capacity(5'd0);
    issue_op(bpl_pkg::FN_INSERT, 5'd0, 32'h2222_2222);
    issue_op(bpl_pkg::FN_DELETE, 5'd0, 32'h0);
    issue_op(bpl_pkg::FN_READ, 5'd0, 32'h0);
    // capacity above depth
    set_capacity(5'd31);
    issue_op(bpl_pkg::FN_APPEND, 5'd0, 32'h7FFF_FFFF);
    issue_op(bpl_pkg::FN_DELETE, 5'd5, 32'h0);
    issue_op(bpl_pkg::FN_DELETE, 5'd0, 32'h0);
    issue_op(bpl_pkg::FN_DELETE, 5'd0, 32'h0);

    for (k = 0; k < 10; k++) begin
      set_capacity((k == 7) ? bpl_pkg::CAP_W'($urandom) : caps[k]);
      for (n = 0; n < PHASE_ITEMS; n++) random_op(((n / 45) % 2) == 0);
    end

    set_capacity(bpl_pkg::CAP_RESET);
    calm = 1'b1;
    for (n = 0; n < CALM_ITEMS; n++) random_op(n < 120);

    settle();
    $display("Summary: %0d list operations over %0d capacity writes;", n_ops, n_cfg);
    $display("Summary: %0d responses checked, %0d refused.", checked, refused);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
